### src/gpsd_pkg.sv
`default_nettype none

package gpsd_pkg;

  localparam int COS_TABLE_DEPTH = 1024;
  localparam int IDX_W = $clog2(COS_TABLE_DEPTH);
  localparam int QEST_W = $clog2(COS_TABLE_DEPTH + 1);

  localparam int LAT_W = 31;
  localparam int LON_W = 32;
  localparam int RADIUS_W = 23;
  localparam int MLAT_W = 30;
  localparam int OFS_W = 32;
  localparam int T_W = 17;
  localparam int DIST_W = 29;

  localparam longint MAX_LON = 64'sd1800000000;
  localparam logic signed [LON_W:0] LON_LIM = (LON_W + 1)'(MAX_LON);
  localparam logic signed [LON_W:0] LON_SPAN = (LON_W + 1)'(2 * MAX_LON);
  localparam longint unsigned LAT_LIMIT = 64'd900000000;

  localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;
  localparam longint unsigned RAD_Q60 = PI_Q60 / 64'd1800000000;
  localparam int SN_W = $clog2(RAD_Q60 + 1);
  localparam logic [SN_W-1:0] SN_RESET =
    SN_W'(((64'd6371000 * RAD_Q60) + (64'd1 << 22)) >> 23);

  // Index estimate: floor(mlat * depth / 9e8) from a reciprocal, one short at most.
  localparam int RECIP_SHIFT = 40;
  localparam longint unsigned IDX_RECIP =
    (longint'(COS_TABLE_DEPTH) << RECIP_SHIFT) / LAT_LIMIT;
  localparam int RECIP_W = $clog2(IDX_RECIP + 1);
  localparam int CMP_W = $clog2((longint'(COS_TABLE_DEPTH) + 2) * LAT_LIMIT + 1);

  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [T_W-1:0] T_ONE = T_W'(65536);

  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam longint unsigned COS_DIV = 64'd4 * COS_TABLE_DEPTH;
  localparam longint unsigned TAYLOR_DIV [1:7] = '{2, 12, 30, 56, 90, 132, 182};

  typedef logic signed [OFS_W-1:0] ofs_t;
  typedef logic [16:0] cos_t;
  typedef logic [T_W-1:0] frac_t;
  typedef cos_t cos_table_t [COS_TABLE_DEPTH];

  typedef struct packed {
    ofs_t ax;
    ofs_t ay;
    ofs_t bx;
    ofs_t by;
  } ends_t;

  typedef struct packed {
    ofs_t  ax;
    ofs_t  ay;
    ofs_t  vx;
    ofs_t  vy;
    frac_t t;
    logic  degen;
  } proj_t;

  typedef struct packed {
    logic [63:0] sum;
    frac_t       t;
    logic        degen;
  } sq_t;

  typedef struct packed {
    logic [31:0] root;
    frac_t       t;
    logic        degen;
  } root_t;

  function automatic cos_t cos_entry(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    longint r;
    x = (longint'(2 * k + 1) * (PI_Q60 >> 30)) / COS_DIV;
    x2 = (x * x) >> 30;
    r = ONE_Q30;
    for (int n = 7; n >= 1; n--) begin
      p = (x2 * longint'(r)) >> 30;
      r = ONE_Q30 - longint'(p / TAYLOR_DIV[n]);
      if (r < 0) begin
        r = 0;
      end
    end
    r = (r + (64'sd1 << 13)) >>> 14;
    return (r > 65536) ? cos_t'(65536) : cos_t'(r);
  endfunction

  function automatic cos_table_t build_cos_table();
    cos_table_t tb;
    for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
      tb[k] = cos_entry(k);
    end
    return tb;
  endfunction

  localparam cos_table_t COS_TABLE = build_cos_table();

  // Signed shift right, rounding half away from zero.
  function automatic logic signed [63:0] round_shr(logic signed [63:0] v, int sh);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [LON_W-1:0] lon_wrap(logic signed [LON_W-1:0] from,
                                                       logic signed [LON_W-1:0] to);
    logic signed [LON_W:0] d;
    d = (LON_W + 1)'(to) - (LON_W + 1)'(from);
    if (d > LON_LIM) begin
      d = d - LON_SPAN;
    end else if (d < -LON_LIM) begin
      d = d + LON_SPAN;
    end
    return d[LON_W-1:0];
  endfunction

endpackage

`default_nettype wire

### src/gpsd_front.sv
`default_nettype none

module gpsd_front import gpsd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    run,
  input  logic                    in_valid,
  input  logic signed [LAT_W-1:0] p_lat,
  input  logic signed [LON_W-1:0] p_lon,
  input  logic signed [LAT_W-1:0] a_lat,
  input  logic signed [LON_W-1:0] a_lon,
  input  logic signed [LAT_W-1:0] b_lat,
  input  logic signed [LON_W-1:0] b_lon,
  input  logic [SN_W-1:0]         sn,
  output logic                    out_valid,
  output ends_t                   out_ends
);

  typedef struct packed {
    logic signed [31:0] dlon_a;
    logic signed [31:0] dlon_b;
    logic signed [31:0] dlat_a;
    logic signed [31:0] dlat_b;
  } delta_t;

  logic [6:0] vld;

  delta_t d1, d2, d3, d4, d5;
  logic [MLAT_W-1:0] mlat1, mlat2;
  logic [QEST_W-1:0] q2;
  logic [IDX_W-1:0] idx3;
  cos_t cos4;
  logic [SN_W-1:0] se5;
  logic signed [63:0] pax6, pay6, pbx6, pby6;

  delta_t d_in;
  logic signed [31:0] plat_ext;
  logic [31:0] plat_mag;
  logic [MLAT_W-1:0] mlat_in;
  logic [MLAT_W+RECIP_W-1:0] est_prod;
  logic [CMP_W-1:0] hi, lo;
  logic [QEST_W:0] qc;
  logic [IDX_W-1:0] idx_next;
  logic [SN_W+17:0] se_prod;
  logic signed [SN_W:0] se_s, sn_s;

  always_comb begin
    d_in.dlon_a = lon_wrap(p_lon, a_lon);
    d_in.dlon_b = lon_wrap(p_lon, b_lon);
    d_in.dlat_a = 32'(a_lat) - 32'(p_lat);
    d_in.dlat_b = 32'(b_lat) - 32'(p_lat);
    plat_ext = 32'(p_lat);
    plat_mag = plat_ext[31] ? 32'(-plat_ext) : 32'(plat_ext);
    mlat_in = (64'(plat_mag) > LAT_LIMIT) ? MLAT_W'(LAT_LIMIT) : plat_mag[MLAT_W-1:0];

    est_prod = (MLAT_W + RECIP_W)'(mlat1) * (MLAT_W + RECIP_W)'(IDX_RECIP);

    hi = (CMP_W'(q2) + CMP_W'(1)) * CMP_W'(LAT_LIMIT);
    lo = CMP_W'(mlat2) * CMP_W'(COS_TABLE_DEPTH);
    qc = (hi <= lo) ? (QEST_W + 1)'(q2) + (QEST_W + 1)'(1) : (QEST_W + 1)'(q2);
    idx_next = (qc >= (QEST_W + 1)'(COS_TABLE_DEPTH)) ? IDX_W'(COS_TABLE_DEPTH - 1)
                                                      : qc[IDX_W-1:0];

    se_prod = (SN_W + 18)'(sn) * (SN_W + 18)'(cos4) + (SN_W + 18)'(1 << 15);

    se_s = $signed({1'b0, se5});
    sn_s = $signed({1'b0, sn});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (run) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      d1 <= d_in;
      mlat1 <= mlat_in;
      d2 <= d1;
      mlat2 <= mlat1;
      q2 <= est_prod[RECIP_SHIFT +: QEST_W];
      d3 <= d2;
      idx3 <= idx_next;
      d4 <= d3;
      cos4 <= COS_TABLE[idx3];
      d5 <= d4;
      se5 <= se_prod[16 +: SN_W];
      pax6 <= d5.dlon_a * se_s;
      pbx6 <= d5.dlon_b * se_s;
      pay6 <= d5.dlat_a * sn_s;
      pby6 <= d5.dlat_b * sn_s;
      out_ends.ax <= ofs_t'(round_shr(pax6, 32));
      out_ends.ay <= ofs_t'(round_shr(pay6, 32));
      out_ends.bx <= ofs_t'(round_shr(pbx6, 32));
      out_ends.by <= ofs_t'(round_shr(pby6, 32));
    end
  end

  assign out_valid = vld[6];

endmodule

`default_nettype wire

### src/gpsd_proj.sv
`default_nettype none

module gpsd_proj import gpsd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  run,
  input  logic  in_valid,
  input  ends_t in_ends,
  output logic  out_valid,
  output proj_t out_proj
);

  localparam int STEPS = 16;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] len;
    logic [15:0] q;
    logic        full;
    logic        active;
    logic        degen;
    ofs_t        ax;
    ofs_t        ay;
    ofs_t        vx;
    ofs_t        vy;
  } div_t;

  logic [1:0] vld;
  ofs_t ax1, ay1, vx1, vy1;
  ofs_t ax2, ay2, vx2, vy2;
  logic signed [63:0] sqx2, sqy2, dx2, dy2;

  logic [STEPS:0] dvld;
  div_t dv [STEPS+1];

  logic [63:0] len_c;
  logic signed [63:0] dot_c;
  logic [63:0] num_c;
  div_t dv_in;

  function automatic div_t div_step(div_t s);
    div_t n;
    logic [63:0] sh;
    n = s;
    sh = {s.rem[62:0], 1'b0};
    if (sh >= s.len) begin
      n.rem = sh - s.len;
      n.q = {s.q[14:0], 1'b1};
    end else begin
      n.rem = sh;
      n.q = {s.q[14:0], 1'b0};
    end
    return n;
  endfunction

  always_comb begin
    len_c = $unsigned(sqx2) + $unsigned(sqy2);
    dot_c = dx2 + dy2;
    num_c = 64'(-dot_c);
    dv_in.len = len_c;
    dv_in.q = '0;
    dv_in.degen = (len_c == '0);
    dv_in.full = !dv_in.degen && dot_c[63] && (num_c >= len_c);
    dv_in.active = !dv_in.degen && dot_c[63] && (num_c < len_c);
    dv_in.rem = dv_in.active ? num_c : '0;
    dv_in.ax = ax2;
    dv_in.ay = ay2;
    dv_in.vx = vx2;
    dv_in.vy = vy2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      dvld <= '0;
    end else if (run) begin
      vld <= {vld[0], in_valid};
      dvld <= {dvld[STEPS-1:0], vld[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      ax1 <= in_ends.ax;
      ay1 <= in_ends.ay;
      vx1 <= in_ends.bx - in_ends.ax;
      vy1 <= in_ends.by - in_ends.ay;
      ax2 <= ax1;
      ay2 <= ay1;
      vx2 <= vx1;
      vy2 <= vy1;
      sqx2 <= vx1 * vx1;
      sqy2 <= vy1 * vy1;
      dx2 <= ax1 * vx1;
      dy2 <= ay1 * vy1;
      dv[0] <= dv_in;
      for (int i = 0; i < STEPS; i++) begin
        dv[i+1] <= div_step(dv[i]);
      end
    end
  end

  always_comb begin
    out_proj.ax = dv[STEPS].ax;
    out_proj.ay = dv[STEPS].ay;
    out_proj.vx = dv[STEPS].vx;
    out_proj.vy = dv[STEPS].vy;
    out_proj.degen = dv[STEPS].degen;
    if (dv[STEPS].full) begin
      out_proj.t = T_ONE;
    end else if (dv[STEPS].active) begin
      out_proj.t = T_W'(dv[STEPS].q);
    end else begin
      out_proj.t = '0;
    end
  end

  assign out_valid = dvld[STEPS];

endmodule

`default_nettype wire

### src/gpsd_near.sv
`default_nettype none

module gpsd_near import gpsd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  run,
  input  logic  in_valid,
  input  proj_t in_proj,
  output logic  out_valid,
  output sq_t   out_sq
);

  logic [3:0] vld;
  ofs_t ax1, ay1;
  logic signed [49:0] tvx1, tvy1;
  ofs_t cx2, cy2;
  logic signed [63:0] sqx3, sqy3;
  frac_t t1, t2, t3;
  logic dg1, dg2, dg3;
  logic signed [T_W:0] t_s;

  assign t_s = $signed({1'b0, in_proj.t});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (run) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      ax1 <= in_proj.ax;
      ay1 <= in_proj.ay;
      tvx1 <= t_s * in_proj.vx;
      tvy1 <= t_s * in_proj.vy;
      t1 <= in_proj.t;
      dg1 <= in_proj.degen;
      cx2 <= ax1 + ofs_t'(round_shr(64'(tvx1), 16));
      cy2 <= ay1 + ofs_t'(round_shr(64'(tvy1), 16));
      t2 <= t1;
      dg2 <= dg1;
      sqx3 <= cx2 * cx2;
      sqy3 <= cy2 * cy2;
      t3 <= t2;
      dg3 <= dg2;
      out_sq.sum <= $unsigned(sqx3) + $unsigned(sqy3);
      out_sq.t <= t3;
      out_sq.degen <= dg3;
    end
  end

  assign out_valid = vld[3];

endmodule

`default_nettype wire

### src/gpsd_sqrt.sv
`default_nettype none

module gpsd_sqrt import gpsd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  run,
  input  logic  in_valid,
  input  sq_t   in_sq,
  output logic  out_valid,
  output root_t out_root
);

  localparam int STEPS = 32;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] res;
    frac_t       t;
    logic        degen;
  } sqrt_st_t;

  logic [STEPS-1:0] vld;
  sqrt_st_t st [STEPS];
  sqrt_st_t st_in;

  // One digit of the root per stage; the trial bit walks down two places each time.
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, int i);
    sqrt_st_t n;
    logic [63:0] bitv;
    logic [63:0] trial;
    n = s;
    bitv = 64'd1 << (62 - 2 * i);
    trial = s.res + bitv;
    if (s.v >= trial) begin
      n.v = s.v - trial;
      n.res = (s.res >> 1) + bitv;
    end else begin
      n.res = s.res >> 1;
    end
    return n;
  endfunction

  always_comb begin
    st_in.v = in_sq.sum;
    st_in.res = '0;
    st_in.t = in_sq.t;
    st_in.degen = in_sq.degen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (run) begin
      vld <= {vld[STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      st[0] <= sqrt_step(st_in, 0);
      for (int i = 1; i < STEPS; i++) begin
        st[i] <= sqrt_step(st[i-1], i);
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign out_root.root = st[STEPS-1].res[31:0];
  assign out_root.t = st[STEPS-1].t;
  assign out_root.degen = st[STEPS-1].degen;

endmodule

`default_nettype wire

### src/geo_point_segment_distance.sv
// Throughput: one transaction per cycle while in_ready is high; the projection
// divider (16 stages) and the square root (32 stages) are fully pipelined, one
// digit per stage.
// Reset: synchronous, active high; clears all valid bits and the skid buffer, and
// loads the meridian scale for an earth radius of 6371000 m.
`default_nettype none

module geo_point_segment_distance import gpsd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [RADIUS_W-1:0]     cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [LAT_W-1:0] p_lat,
  input  logic signed [LON_W-1:0] p_lon,
  input  logic signed [LAT_W-1:0] a_lat,
  input  logic signed [LON_W-1:0] a_lon,
  input  logic signed [LAT_W-1:0] b_lat,
  input  logic signed [LON_W-1:0] b_lon,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [DIST_W-1:0]       dist_sixteenths,
  output logic [T_W-1:0]          proj_pos,
  output logic                    degenerate,
  output logic                    saturated
);

  typedef struct packed {
    logic [DIST_W-1:0] sixteenths;
    frac_t             t;
    logic              degen;
    logic              sat;
  } result_t;

  logic [SN_W-1:0] sn;
  logic [RADIUS_W+SN_W:0] sn_prod;

  logic run;
  logic front_valid, proj_valid, near_valid, last_valid;
  ends_t front_ends;
  proj_t proj_data;
  sq_t near_data;
  root_t root_data;

  logic [32:0] half_root;
  result_t last_res;
  result_t out_res;
  result_t skid_res;
  logic skid_valid;
  logic take;
  logic push;

  assign sn_prod = (RADIUS_W + SN_W + 1)'(cfg_wdata) * (RADIUS_W + SN_W + 1)'(RAD_Q60)
                   + (RADIUS_W + SN_W + 1)'(1 << 22);

  always_ff @(posedge clk) begin
    if (rst) begin
      sn <= SN_RESET;
    end else if (cfg_we) begin
      sn <= sn_prod[23 +: SN_W];
    end
  end

  // The whole pipeline moves together; the skid entry absorbs the one result
  // that arrives while the output register is held.
  assign run = !skid_valid;
  assign in_ready = run;

  gpsd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .run      (run),
    .in_valid (in_valid),
    .p_lat    (p_lat),
    .p_lon    (p_lon),
    .a_lat    (a_lat),
    .a_lon    (a_lon),
    .b_lat    (b_lat),
    .b_lon    (b_lon),
    .sn       (sn),
    .out_valid(front_valid),
    .out_ends (front_ends)
  );

  gpsd_proj u_proj (
    .clk      (clk),
    .rst      (rst),
    .run      (run),
    .in_valid (front_valid),
    .in_ends  (front_ends),
    .out_valid(proj_valid),
    .out_proj (proj_data)
  );

  gpsd_near u_near (
    .clk      (clk),
    .rst      (rst),
    .run      (run),
    .in_valid (proj_valid),
    .in_proj  (proj_data),
    .out_valid(near_valid),
    .out_sq   (near_data)
  );

  gpsd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .run      (run),
    .in_valid (near_valid),
    .in_sq    (near_data),
    .out_valid(last_valid),
    .out_root (root_data)
  );

  always_comb begin
    half_root = (33'(root_data.root) + 33'd1) >> 1;
    last_res.sat = (half_root > 33'(DIST_MAX));
    last_res.sixteenths = last_res.sat ? DIST_MAX : half_root[DIST_W-1:0];
    last_res.t = root_data.t;
    last_res.degen = root_data.degen;
  end

  assign take = out_valid && out_ready;
  assign push = run && last_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || take) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_res <= skid_res;
      end
    end else if (!out_valid || take) begin
      if (push) begin
        out_res <= last_res;
      end
    end else if (push) begin
      skid_res <= last_res;
    end
  end

  assign dist_sixteenths = out_res.sixteenths;
  assign proj_pos = out_res.t;
  assign degenerate = out_res.degen;
  assign saturated = out_res.sat;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && !skid_valid && last_valid |=> skid_valid)
    else $error("result arriving at a held output was not caught by the skid entry");

  a_sat_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> dist_sixteenths == DIST_MAX)
    else $error("saturated result without the clamped distance");

  a_degen_t: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> proj_pos == '0)
    else $error("degenerate segment with a nonzero projection");

  a_t_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> proj_pos <= T_ONE)
    else $error("projection parameter beyond one");

endmodule

`default_nettype wire
